@@ rtl/rie_pkg.sv @@
// Shared types and constants of the instruction execute block.
// Holds the opcode and class codes, the queued item and result structs,
// and the classify function. Depends on nothing.
package rie_pkg;

    localparam int REG_COUNT = 16;
    localparam logic [11:0] PC_MASK = 12'hFFF;
    localparam logic [31:0] IO_ZERO_ADDR = 32'd22;
    localparam logic [3:0] LAST_FIXED_REG = 4'd2;

    typedef enum logic [7:0] {
        OP_ADD  = 8'd0,
        OP_SUB  = 8'd1,
        OP_MAC  = 8'd2,
        OP_AND  = 8'd3,
        OP_OR   = 8'd4,
        OP_XOR  = 8'd5,
        OP_SLL  = 8'd6,
        OP_SRA  = 8'd7,
        OP_SRL  = 8'd8,
        OP_BEQ  = 8'd9,
        OP_BNE  = 8'd10,
        OP_BLT  = 8'd11,
        OP_BGT  = 8'd12,
        OP_BLE  = 8'd13,
        OP_BGE  = 8'd14,
        OP_JAL  = 8'd15,
        OP_LW   = 8'd16,
        OP_SW   = 8'd17,
        OP_RETI = 8'd18,
        OP_IN   = 8'd19,
        OP_OUT  = 8'd20,
        OP_HALT = 8'd21
    } op_t;

    typedef enum logic [3:0] {
        CLS_NOP,
        CLS_ALU,
        CLS_BRANCH,
        CLS_JAL,
        CLS_LOAD,
        CLS_STORE,
        CLS_RETI,
        CLS_IN,
        CLS_OUT,
        CLS_HALT,
        CLS_PRELOAD
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [7:0]  opcode;
        logic [3:0]  rd;
        logic [3:0]  rs;
        logic [3:0]  rt;
        logic [3:0]  rm;
        logic [11:0] imm1;
        logic [11:0] imm2;
        logic [11:0] laddr;
        logic [31:0] lword;
    } item_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        halted;
        logic        reg_write;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [11:0] mem_addr;
        logic [31:0] mem_value;
        logic        io_write;
        logic [4:0]  io_addr;
        logic [31:0] io_value;
    } res_t;

    function automatic cls_t classify(input logic mode, input logic [7:0] op);
        cls_t c;
        begin
            c = CLS_NOP;
            if (mode)
            begin
                c = CLS_PRELOAD;
            end
            else
            begin
                case (op) inside
                    [OP_ADD:OP_SRL]: c = CLS_ALU;
                    [OP_BEQ:OP_BGE]: c = CLS_BRANCH;
                    OP_JAL:          c = CLS_JAL;
                    OP_LW:           c = CLS_LOAD;
                    OP_SW:           c = CLS_STORE;
                    OP_RETI:         c = CLS_RETI;
                    OP_IN:           c = CLS_IN;
                    OP_OUT:          c = CLS_OUT;
                    OP_HALT:         c = CLS_HALT;
                    default:         c = CLS_NOP;
                endcase
            end
            return c;
        end
    endfunction

endpackage

@@ rtl/rie_front.sv @@
// Front end: accepts input transactions, classifies them and holds them
// in a two-entry queue for the back end. Depends on rie_pkg.
module rie_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           hold,
    input  logic           mode,
    input  logic [7:0]     opcode,
    input  logic [3:0]     dest_sel,
    input  logic [3:0]     src_a_sel,
    input  logic [3:0]     src_b_sel,
    input  logic [3:0]     src_c_sel,
    input  logic [11:0]    imm_first,
    input  logic [11:0]    imm_second,
    input  logic [11:0]    load_addr,
    input  logic [31:0]    load_word,
    output logic           q_valid,
    output rie_pkg::item_t q_item,
    input  logic           q_pop
);
    import rie_pkg::*;

    item_t       buf_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    item_t       new_item;

    assign in_stall = (cnt_reg == 2'd2) || hold;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rptr_reg];

    always_comb
    begin
        new_item.cls    = classify(mode, opcode);
        new_item.opcode = opcode;
        new_item.rd     = dest_sel;
        new_item.rs     = src_a_sel;
        new_item.rt     = src_b_sel;
        new_item.rm     = src_c_sel;
        new_item.imm1   = imm_first;
        new_item.imm2   = imm_second;
        new_item.laddr  = load_addr;
        new_item.lword  = load_word;
    end

    always_comb
    begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = q_pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wptr_reg] <= new_item;
        end
    end

endmodule

@@ rtl/rie_back.sv @@
// Back end: executes queued items against the register file, data memory,
// I/O registers, pc and halt flag, and drives the result register.
// Depends on rie_pkg.
module rie_back #(
    parameter int MEM_DEPTH = 4096,
    parameter int IO_COUNT  = 23
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rie_pkg::item_t q_item,
    output logic           q_pop,
    output logic           clearing,
    output logic           out_valid,
    input  logic           out_stall,
    output rie_pkg::res_t  out_res
);
    import rie_pkg::*;

    localparam int AW     = $clog2(MEM_DEPTH);
    localparam int IA     = $clog2(IO_COUNT);
    localparam int MSTEPS = $clog2((4096 + MEM_DEPTH - 1) / MEM_DEPTH);

    function automatic logic [AW-1:0] mem_mod(input logic [11:0] v);
        logic [13:0] t;
        begin
            t = {2'b00, v};
            for (int k = MSTEPS - 1; k >= 0; k--)
            begin
                if (t >= 14'(MEM_DEPTH << k))
                begin
                    t = t - 14'(MEM_DEPTH << k);
                end
            end
            return t[AW-1:0];
        end
    endfunction

    logic [31:0]   rf_reg [REG_COUNT];
    logic [31:0]   io_reg [IO_COUNT];
    logic [31:0]   mem [MEM_DEPTH];
    logic [31:0]   rdata_reg;
    logic [11:0]   pc_reg;
    logic          halt_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_idx_reg;

    res_t          e2_reg;
    logic          e2_valid_reg;
    logic          e2_lw_reg;
    logic [31:0]   e2_c_reg;
    res_t          out_reg;
    logic          out_valid_reg;

    logic [31:0]   a, b, c, d, sum, rv;
    logic          rw, is_lw, io_we, reti;
    logic [AW-1:0] maddr;
    logic [IA-1:0] io_idx;
    res_t          r;
    res_t          e2_fin;
    logic          e2_adv, hazard, fire;

    function automatic logic [31:0] rd_val(input logic [3:0] idx, input item_t it,
                                           input logic [31:0] stored);
        logic [31:0] v;
        begin
            case (idx)
                4'd0:    v = 32'd0;
                4'd1:    v = {20'd0, it.imm1};
                4'd2:    v = {20'd0, it.imm2};
                default: v = stored;
            endcase
            return v;
        end
    endfunction

    always_comb
    begin
        a      = rd_val(q_item.rs, q_item, rf_reg[q_item.rs]);
        b      = rd_val(q_item.rt, q_item, rf_reg[q_item.rt]);
        c      = rd_val(q_item.rm, q_item, rf_reg[q_item.rm]);
        d      = rd_val(q_item.rd, q_item, rf_reg[q_item.rd]);
        sum    = a + b;
        io_idx = sum[IA-1:0];
        maddr  = mem_mod(sum[11:0]);
        rw     = 1'b0;
        rv     = 32'd0;
        is_lw  = 1'b0;
        io_we  = 1'b0;
        reti   = 1'b0;
        r      = '0;
        r.next_pc = (pc_reg + 12'd1) & PC_MASK;
        r.halted  = halt_reg;
        if (q_item.cls == CLS_PRELOAD)
        begin
            maddr       = mem_mod(q_item.laddr);
            r.mem_write = 1'b1;
            r.mem_addr  = 12'(maddr);
            r.mem_value = q_item.lword;
            r.next_pc   = pc_reg;
        end
        else if (halt_reg)
        begin
            r.next_pc = pc_reg;
        end
        else
        begin
            case (q_item.cls)
                CLS_ALU:
                begin
                    rw = 1'b1;
                    case (q_item.opcode)
                        OP_ADD:  rv = a + b + c;
                        OP_SUB:  rv = a - b - c;
                        OP_MAC:  rv = a * b + c;
                        OP_AND:  rv = a & b & c;
                        OP_OR:   rv = a | b | c;
                        OP_XOR:  rv = a ^ b ^ c;
                        OP_SLL:  rv = (b[31:5] != 27'd0) ? 32'd0 : (a << b[4:0]);
                        OP_SRA:  rv = (b[31:5] != 27'd0) ? {32{a[31]}}
                                                         : 32'($signed(a) >>> b[4:0]);
                        OP_SRL:  rv = (b[31:5] != 27'd0) ? 32'd0 : (a >> b[4:0]);
                        default: rv = 32'd0;
                    endcase
                end
                CLS_BRANCH:
                begin
                    case (q_item.opcode)
                        OP_BEQ:  if (a == b) r.next_pc = c[11:0];
                        OP_BNE:  if (a != b) r.next_pc = c[11:0];
                        OP_BLT:  if ($signed(a) < $signed(b)) r.next_pc = c[11:0];
                        OP_BGT:  if ($signed(a) > $signed(b)) r.next_pc = c[11:0];
                        OP_BLE:  if ($signed(a) <= $signed(b)) r.next_pc = c[11:0];
                        OP_BGE:  if ($signed(a) >= $signed(b)) r.next_pc = c[11:0];
                        default: r.next_pc = r.next_pc;
                    endcase
                end
                CLS_JAL:
                begin
                    if (q_item.rd > LAST_FIXED_REG)
                    begin
                        rw        = 1'b1;
                        rv        = {20'd0, (pc_reg + 12'd1) & PC_MASK};
                        r.next_pc = c[11:0];
                    end
                end
                CLS_LOAD:
                begin
                    rw    = 1'b1;
                    is_lw = 1'b1;
                end
                CLS_STORE:
                begin
                    r.mem_write = 1'b1;
                    r.mem_addr  = 12'(maddr);
                    r.mem_value = c + d;
                end
                CLS_RETI:
                begin
                    reti      = 1'b1;
                    r.next_pc = io_reg[7][11:0];
                end
                CLS_IN:
                begin
                    rw = 1'b1;
                    if (sum != IO_ZERO_ADDR && sum < 32'(IO_COUNT))
                    begin
                        rv = io_reg[io_idx];
                    end
                end
                CLS_OUT:
                begin
                    if (sum < 32'(IO_COUNT))
                    begin
                        io_we      = 1'b1;
                        r.io_write = 1'b1;
                        r.io_addr  = 5'(io_idx);
                        r.io_value = c;
                    end
                end
                CLS_HALT:
                begin
                    r.halted  = 1'b1;
                    r.next_pc = pc_reg;
                end
                default:
                begin
                    r.next_pc = r.next_pc;
                end
            endcase
        end
        // Writes aimed at the zero and immediate registers are dropped.
        if (rw && q_item.rd > LAST_FIXED_REG)
        begin
            r.reg_write = 1'b1;
            r.reg_index = q_item.rd;
            r.reg_value = rv;
        end
    end

    // A load's value comes from the registered memory read; hold the next item until it lands.
    assign hazard = e2_valid_reg && e2_lw_reg && e2_reg.reg_write;
    assign e2_adv = e2_valid_reg && (!out_valid_reg || !out_stall);
    assign fire   = q_valid && !clr_busy_reg && (!e2_valid_reg || e2_adv) && !hazard;
    assign q_pop  = fire;

    always_comb
    begin
        e2_fin = e2_reg;
        if (e2_lw_reg && e2_reg.reg_write)
        begin
            e2_fin.reg_value = rdata_reg + e2_c_reg;
        end
    end

    assign clearing  = clr_busy_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
        end
        else if (e2_adv && e2_lw_reg && e2_reg.reg_write)
        begin
            rf_reg[e2_reg.reg_index] <= e2_fin.reg_value;
        end
        else if (fire && r.reg_write && !is_lw)
        begin
            rf_reg[r.reg_index] <= r.reg_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < IO_COUNT; i++)
            begin
                io_reg[i] <= 32'd0;
            end
        end
        else if (fire && io_we)
        begin
            io_reg[io_idx] <= c;
        end
        else if (fire && reti)
        begin
            io_reg[3] <= 32'd0;
            io_reg[4] <= 32'd0;
            io_reg[5] <= 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= 12'd0;
            halt_reg      <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            e2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(MEM_DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (fire)
            begin
                pc_reg   <= r.next_pc;
                halt_reg <= r.halted;
            end
            if (fire)
            begin
                e2_valid_reg <= 1'b1;
            end
            else if (e2_adv)
            begin
                e2_valid_reg <= 1'b0;
            end
            if (e2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            e2_reg    <= r;
            e2_lw_reg <= is_lw;
            e2_c_reg  <= c;
        end
        if (e2_adv)
        begin
            out_reg <= e2_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_idx_reg] <= 32'd0;
        end
        else if (fire && r.mem_write)
        begin
            mem[maddr] <= r.mem_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && is_lw)
        begin
            rdata_reg <= mem[maddr];
        end
    end

endmodule

@@ rtl/risc_instruction_execute.sv @@
// Top level of the instruction execute block: front end with its queue,
// and the back end that executes. Depends on rie_pkg, rie_front, rie_back.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    mode, opcode, dest_sel .. load_word
//   out      out_valid / out_stall  next_pc, halted, reg_*, mem_*, io_*
//
// One instruction or preload transaction is executed per cycle, except while the
// memory is cleared, a load's data is pending or the output is stalled. A load
// (lw) returns its data from the registered memory read, so the item after a
// load that writes a register waits until that data has landed. A transaction
// goes from input to result through the queue, execute and memory return, then
// the result register. After reset the data memory is cleared one word a cycle
// while in_stall stays high. A stall on the output backs up into the two-entry
// queue; the front end keeps taking transactions until the queue is full.
module risc_instruction_execute #(
    parameter int MEM_DEPTH = 4096,
    parameter int IO_COUNT  = 23
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  opcode,
    input  logic [3:0]  dest_sel,
    input  logic [3:0]  src_a_sel,
    input  logic [3:0]  src_b_sel,
    input  logic [3:0]  src_c_sel,
    input  logic [11:0] imm_first,
    input  logic [11:0] imm_second,
    input  logic [11:0] load_addr,
    input  logic [31:0] load_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] next_pc,
    output logic        halted,
    output logic        reg_write,
    output logic [3:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        mem_write,
    output logic [11:0] mem_addr,
    output logic [31:0] mem_value,
    output logic        io_write,
    output logic [4:0]  io_addr,
    output logic [31:0] io_value
);
    import rie_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;
    logic  clearing;
    res_t  res;

    rie_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hold       (clearing),
        .mode       (mode),
        .opcode     (opcode),
        .dest_sel   (dest_sel),
        .src_a_sel  (src_a_sel),
        .src_b_sel  (src_b_sel),
        .src_c_sel  (src_c_sel),
        .imm_first  (imm_first),
        .imm_second (imm_second),
        .load_addr  (load_addr),
        .load_word  (load_word),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    rie_back #(
        .MEM_DEPTH (MEM_DEPTH),
        .IO_COUNT  (IO_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res)
    );

    assign next_pc   = res.next_pc;
    assign halted    = res.halted;
    assign reg_write = res.reg_write;
    assign reg_index = res.reg_index;
    assign reg_value = res.reg_value;
    assign mem_write = res.mem_write;
    assign mem_addr  = res.mem_addr;
    assign mem_value = res.mem_value;
    assign io_write  = res.io_write;
    assign io_addr   = res.io_addr;
    assign io_value  = res.io_value;

    // No transaction enters while the memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> in_stall)
        else $error("input accepted during memory clear");

    // A transaction makes at most one kind of write.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({reg_write, mem_write, io_write}) <= 1)
        else $error("more than one write in one result");

    // Register writes never target the zero or immediate registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reg_write) |-> reg_index > LAST_FIXED_REG)
        else $error("write to a fixed register reported");

    // A halted machine only reports preload writes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && halted && !mem_write) |-> (!reg_write && !io_write))
        else $error("write reported while halted");

endmodule
